/* hw/rtl/bpc_pkg.sv */
package bpc_pkg;

    // Default sizes of the palette.
    localparam int MAX_BONES_DEF = 256;
    localparam int FRAC_BITS_DEF = 16;

    // Request command codes.
    localparam logic [2:0] CMD_LOCAL  = 3'd0;
    localparam logic [2:0] CMD_OFFSET = 3'd1;
    localparam logic [2:0] CMD_POSE   = 3'd2;
    localparam logic [2:0] CMD_PARENT = 3'd3;
    localparam logic [2:0] CMD_READ   = 3'd4;

    // Datapath operation codes.
    localparam logic [3:0] OP_NONE    = 4'd0;
    localparam logic [3:0] OP_CLEAR   = 4'd1;
    localparam logic [3:0] OP_LOAD_PL = 4'd2;
    localparam logic [3:0] OP_LOAD_PR = 4'd3;
    localparam logic [3:0] OP_LOAD_OC = 4'd4;
    localparam logic [3:0] OP_MUL     = 4'd5;
    localparam logic [3:0] OP_WR_COMB = 4'd6;
    localparam logic [3:0] OP_WR_PAL  = 4'd7;
    localparam logic [3:0] OP_READ    = 4'd8;

    // One matrix row of four elements, and a whole 4x4 matrix.
    typedef logic [3:0][31:0] row_t;
    typedef logic [3:0][3:0][31:0] mat_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic [3:0] op;
        logic       start;
        logic       capture;
        logic       hwr;
        logic       sat_clr;
        logic       rd_zero;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       done;
        logic       par_root;
        logic [2:0] req_cmd;
        logic [7:0] req_bone;
    } dp_stat_t;

endpackage

/* hw/rtl/bpc_datapath.sv */
module bpc_datapath #(
    parameter int MAX_BONES = 256,
    parameter int FRAC_BITS = 16,
    parameter int BIDX_W    = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bpc_pkg::dp_cmd_t     dp_cmd,
    input  logic [BIDX_W-1:0]    bone_idx,
    input  logic [2:0]           cmd,
    input  logic [7:0]           bone,
    input  logic [1:0]           row,
    input  bpc_pkg::row_t        in_row,
    input  logic [7:0]           parent_bone,
    input  logic                 is_root,
    output bpc_pkg::dp_stat_t    dp_stat,
    output bpc_pkg::row_t        out_row,
    output logic                 out_sat
);
    import bpc_pkg::*;

    localparam int ADDR_W = BIDX_W + 2;
    localparam int DEPTH  = MAX_BONES * 4;
    localparam int OPC_W  = (ADDR_W > 7) ? ADDR_W : 7;
    localparam logic [31:0] ONE = 32'(1) << FRAC_BITS;

    // Request registers.
    logic [2:0]  req_cmd_reg;
    logic [7:0]  req_bone_reg;
    logic [1:0]  req_row_reg;
    row_t        req_data_reg;
    logic [7:0]  req_par_reg;
    logic        req_root_reg;

    // Operation sequencing.
    logic             busy_reg;
    logic [3:0]       op_reg;
    logic [OPC_W-1:0] cnt_reg;
    logic             done;
    logic             clearing;

    // Matrix registers.
    mat_t a_reg;
    mat_t b_reg;
    mat_t t_reg;

    // Load capture pipeline.
    logic       cap_vld_reg;
    logic [1:0] cap_row_reg;

    // Multiply pipeline.
    logic               pv_reg;
    logic [1:0]         pi_reg;
    logic [1:0]         pj_reg;
    logic [1:0]         pk_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic signed [63:0] term;
    logic signed [63:0] sum;
    logic signed [31:0] a_el;
    logic signed [31:0] b_el;
    logic [31:0]        sat_val;
    logic               sat_hit;
    logic               sat_seen_reg;

    // Memories and their ports.
    logic [127:0] local_mem  [DEPTH];
    logic [127:0] offset_mem [DEPTH];
    logic [127:0] pose_mem   [DEPTH];
    logic [127:0] comb_mem   [DEPTH];
    logic [127:0] pal_mem    [DEPTH];
    logic [8:0]   par_mem    [MAX_BONES];

    logic [127:0] local_rd_reg;
    logic [127:0] offset_rd_reg;
    logic [127:0] pose_rd_reg;
    logic [127:0] comb_rd_reg;
    logic [127:0] pal_rd_reg;
    logic [8:0]   par_reg;

    logic [ADDR_W-1:0] host_addr;
    logic [ADDR_W-1:0] walk_addr;
    logic [ADDR_W-1:0] comb_rd_addr;
    logic [ADDR_W-1:0] pal_rd_addr;
    logic [ADDR_W-1:0] in_wr_addr;
    logic [ADDR_W-1:0] out_wr_addr;
    logic [BIDX_W-1:0] par_idx;
    logic [BIDX_W-1:0] par_wr_addr;
    row_t              id_row;
    row_t              in_wr_data;
    row_t              out_wr_data;
    logic [8:0]        par_wr_data;
    logic              local_we;
    logic              offset_we;
    logic              pose_we;
    logic              comb_we;
    logic              pal_we;
    logic              par_we;

    row_t out_row_reg;
    logic out_sat_reg;

    // Addresses and write controls.
    always_comb
    begin
        clearing    = busy_reg && (op_reg == OP_CLEAR);
        host_addr   = {BIDX_W'(req_bone_reg), req_row_reg};
        walk_addr   = {bone_idx, cnt_reg[1:0]};
        par_idx     = BIDX_W'(par_reg[7:0]);
        comb_rd_addr = (op_reg == OP_LOAD_PR) ? {par_idx, cnt_reg[1:0]} : walk_addr;
        pal_rd_addr = host_addr;
        for (int c = 0; c < 4; c++)
        begin
            id_row[c] = (c == int'(cnt_reg[1:0])) ? ONE : 32'd0;
        end
        in_wr_addr  = clearing ? cnt_reg[ADDR_W-1:0] : host_addr;
        in_wr_data  = clearing ? id_row : req_data_reg;
        out_wr_addr = clearing ? cnt_reg[ADDR_W-1:0] : walk_addr;
        out_wr_data = clearing ? id_row : t_reg[cnt_reg[1:0]];
        local_we    = clearing || (dp_cmd.hwr && (req_cmd_reg == CMD_LOCAL));
        offset_we   = clearing || (dp_cmd.hwr && (req_cmd_reg == CMD_OFFSET));
        pose_we     = clearing || (dp_cmd.hwr && (req_cmd_reg == CMD_POSE));
        comb_we     = clearing || (busy_reg && (op_reg == OP_WR_COMB));
        pal_we      = clearing || (busy_reg && (op_reg == OP_WR_PAL));
        par_we      = (clearing && (cnt_reg[1:0] == 2'd0))
                      || (dp_cmd.hwr && (req_cmd_reg == CMD_PARENT));
        par_wr_addr = clearing ? cnt_reg[ADDR_W-1:2] : BIDX_W'(req_bone_reg);
        par_wr_data = (clearing || req_root_reg) ? 9'h100 : {1'b0, req_par_reg};
    end

    // Memory writes and registered reads.
    always_ff @(posedge clk)
    begin
        if (local_we)
        begin
            local_mem[in_wr_addr] <= in_wr_data;
        end
        if (offset_we)
        begin
            offset_mem[in_wr_addr] <= in_wr_data;
        end
        if (pose_we)
        begin
            pose_mem[in_wr_addr] <= in_wr_data;
        end
        if (comb_we)
        begin
            comb_mem[out_wr_addr] <= out_wr_data;
        end
        if (pal_we)
        begin
            pal_mem[out_wr_addr] <= out_wr_data;
        end
        if (par_we)
        begin
            par_mem[par_wr_addr] <= par_wr_data;
        end
        local_rd_reg  <= local_mem[walk_addr];
        offset_rd_reg <= offset_mem[walk_addr];
        pose_rd_reg   <= pose_mem[walk_addr];
        comb_rd_reg   <= comb_mem[comb_rd_addr];
        pal_rd_reg    <= pal_mem[pal_rd_addr];
        if (busy_reg && (op_reg == OP_LOAD_PL) && (cnt_reg == '0))
        begin
            par_reg <= par_mem[bone_idx];
        end
    end

    // End of the running operation.
    always_comb
    begin
        done = 1'b0;
        if (busy_reg)
        begin
            case (op_reg)
                OP_CLEAR:   done = (cnt_reg == OPC_W'(DEPTH - 1));
                OP_LOAD_PL,
                OP_LOAD_PR,
                OP_LOAD_OC: done = (cnt_reg == OPC_W'(4));
                OP_MUL:     done = (cnt_reg == OPC_W'(64));
                OP_WR_COMB,
                OP_WR_PAL:  done = (cnt_reg == OPC_W'(3));
                OP_READ:    done = (cnt_reg == OPC_W'(1));
                default:    done = 1'b1;
            endcase
        end
    end

    // Operation sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            op_reg      <= OP_NONE;
            cnt_reg     <= '0;
            cap_vld_reg <= 1'b0;
            pv_reg      <= 1'b0;
        end
        else
        begin
            if (dp_cmd.start)
            begin
                busy_reg <= 1'b1;
                op_reg   <= dp_cmd.op;
                cnt_reg  <= '0;
            end
            else if (done)
            begin
                busy_reg <= 1'b0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + OPC_W'(1);
            end
            cap_vld_reg <= busy_reg && (cnt_reg < OPC_W'(4))
                           && ((op_reg == OP_LOAD_PL) || (op_reg == OP_LOAD_PR)
                               || (op_reg == OP_LOAD_OC));
            pv_reg      <= busy_reg && (op_reg == OP_MUL) && (cnt_reg < OPC_W'(64));
        end
    end

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            req_cmd_reg  <= cmd;
            req_bone_reg <= bone;
            req_row_reg  <= row;
            req_data_reg <= in_row;
            req_par_reg  <= parent_bone;
            req_root_reg <= is_root;
        end
    end

    // Matrix loads.
    always_ff @(posedge clk)
    begin
        cap_row_reg <= cnt_reg[1:0];
        if (dp_cmd.start && (dp_cmd.op == OP_LOAD_PR))
        begin
            a_reg <= t_reg;
        end
        if (cap_vld_reg)
        begin
            case (op_reg)
                OP_LOAD_PL:
                begin
                    a_reg[cap_row_reg] <= pose_rd_reg;
                    b_reg[cap_row_reg] <= local_rd_reg;
                end
                OP_LOAD_OC:
                begin
                    a_reg[cap_row_reg] <= offset_rd_reg;
                    b_reg[cap_row_reg] <= comb_rd_reg;
                end
                default:
                begin
                    b_reg[cap_row_reg] <= comb_rd_reg;
                end
            endcase
        end
    end

    // Multiply stage: one product per cycle, element order i, j, k.
    always_comb
    begin
        a_el = $signed(a_reg[cnt_reg[5:4]][cnt_reg[1:0]]);
        b_el = $signed(b_reg[cnt_reg[1:0]][cnt_reg[3:2]]);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a_el * b_el;
        pi_reg   <= cnt_reg[5:4];
        pj_reg   <= cnt_reg[3:2];
        pk_reg   <= cnt_reg[1:0];
    end

    // Accumulate stage with saturation on the last term.
    always_comb
    begin
        term    = prod_reg >>> FRAC_BITS;
        sum     = ((pk_reg == 2'd0) ? 64'sd0 : acc_reg) + term;
        sat_hit = 1'b1;
        if (sum > 64'sd2147483647)
        begin
            sat_val = 32'h7FFF_FFFF;
        end
        else if (sum < -64'sd2147483648)
        begin
            sat_val = 32'h8000_0000;
        end
        else
        begin
            sat_val = sum[31:0];
            sat_hit = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pv_reg)
        begin
            acc_reg <= sum;
            if (pk_reg == 2'd3)
            begin
                t_reg[pi_reg][pj_reg] <= sat_val;
            end
        end
    end

    // Saturation flag of the most recent recompute.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_seen_reg <= 1'b0;
        end
        else if (dp_cmd.sat_clr)
        begin
            sat_seen_reg <= 1'b0;
        end
        else if (pv_reg && (pk_reg == 2'd3) && sat_hit)
        begin
            sat_seen_reg <= 1'b1;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (busy_reg && (op_reg == OP_READ) && done)
        begin
            out_row_reg <= dp_cmd.rd_zero ? '0 : pal_rd_reg;
            out_sat_reg <= sat_seen_reg;
        end
    end

    always_comb
    begin
        dp_stat.done     = done;
        dp_stat.par_root = par_reg[8] || (32'(par_reg[7:0]) >= 32'(MAX_BONES));
        dp_stat.req_cmd  = req_cmd_reg;
        dp_stat.req_bone = req_bone_reg;
    end

    assign out_row = out_row_reg;
    assign out_sat = out_sat_reg;

endmodule

/* hw/rtl/bpc_ctrl.sv */
module bpc_ctrl #(
    parameter int MAX_BONES = 256,
    parameter int BIDX_W    = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [8:0]           bones_in_use,
    input  bpc_pkg::dp_stat_t    dp_stat,
    output bpc_pkg::dp_cmd_t     dp_cmd,
    output logic [BIDX_W-1:0]    bone_idx
);
    import bpc_pkg::*;

    localparam int CNT_W = $clog2(MAX_BONES + 1);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DISP   = 4'd2;
    localparam logic [3:0] S_LD_PL  = 4'd3;
    localparam logic [3:0] S_MUL_PL = 4'd4;
    localparam logic [3:0] S_LD_PR  = 4'd5;
    localparam logic [3:0] S_MUL_PR = 4'd6;
    localparam logic [3:0] S_WR_C   = 4'd7;
    localparam logic [3:0] S_LD_OC  = 4'd8;
    localparam logic [3:0] S_MUL_OC = 4'd9;
    localparam logic [3:0] S_WR_P   = 4'd10;
    localparam logic [3:0] S_READ   = 4'd11;

    logic [3:0]        state_reg;
    logic [3:0]        state_next;
    logic              go_reg;
    logic [BIDX_W-1:0] i_reg;
    logic [BIDX_W-1:0] i_next;
    logic              stale_reg;
    logic              stale_next;
    logic              out_valid_reg;
    logic [8:0]        bones_reg;
    logic [CNT_W-1:0]  n_cnt;
    logic              in_use;
    logic              last_bone;
    logic              accept;
    logic              is_write;
    logic              hwr_cmd;
    logic              sat_clr_cmd;

    // Bones in use, capped at the palette size.
    always_comb
    begin
        if (32'(bones_reg) > 32'(MAX_BONES))
        begin
            n_cnt = CNT_W'(MAX_BONES);
        end
        else
        begin
            n_cnt = CNT_W'(bones_reg);
        end
        in_use    = 32'(dp_stat.req_bone) < 32'(n_cnt);
        last_bone = (CNT_W'(i_reg) + CNT_W'(1)) == n_cnt;
        is_write  = (dp_stat.req_cmd == CMD_LOCAL) || (dp_stat.req_cmd == CMD_OFFSET)
                    || (dp_stat.req_cmd == CMD_POSE) || (dp_stat.req_cmd == CMD_PARENT);
        accept    = in_valid && !in_stall;
    end

    // Sequencing of requests and the recompute walk.
    always_comb
    begin
        state_next  = state_reg;
        i_next      = i_reg;
        stale_next  = stale_reg;
        hwr_cmd     = 1'b0;
        sat_clr_cmd = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (dp_stat.done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                state_next = S_IDLE;
                if (dp_stat.req_cmd == CMD_READ)
                begin
                    state_next = S_READ;
                    if (stale_reg)
                    begin
                        sat_clr_cmd = 1'b1;
                        i_next      = '0;
                        if (n_cnt == '0)
                        begin
                            stale_next = 1'b0;
                        end
                        else
                        begin
                            state_next = S_LD_PL;
                        end
                    end
                end
                else if (is_write && in_use)
                begin
                    hwr_cmd    = 1'b1;
                    stale_next = 1'b1;
                end
            end
            S_LD_PL:
            begin
                if (dp_stat.done)
                begin
                    state_next = S_MUL_PL;
                end
            end
            S_MUL_PL:
            begin
                if (dp_stat.done)
                begin
                    state_next = dp_stat.par_root ? S_WR_C : S_LD_PR;
                end
            end
            S_LD_PR:
            begin
                if (dp_stat.done)
                begin
                    state_next = S_MUL_PR;
                end
            end
            S_MUL_PR:
            begin
                if (dp_stat.done)
                begin
                    state_next = S_WR_C;
                end
            end
            S_WR_C:
            begin
                if (dp_stat.done)
                begin
                    if (last_bone)
                    begin
                        i_next     = '0;
                        state_next = S_LD_OC;
                    end
                    else
                    begin
                        i_next     = i_reg + BIDX_W'(1);
                        state_next = S_LD_PL;
                    end
                end
            end
            S_LD_OC:
            begin
                if (dp_stat.done)
                begin
                    state_next = S_MUL_OC;
                end
            end
            S_MUL_OC:
            begin
                if (dp_stat.done)
                begin
                    state_next = S_WR_P;
                end
            end
            S_WR_P:
            begin
                if (dp_stat.done)
                begin
                    if (last_bone)
                    begin
                        stale_next = 1'b0;
                        state_next = S_READ;
                    end
                    else
                    begin
                        i_next     = i_reg + BIDX_W'(1);
                        state_next = S_LD_OC;
                    end
                end
            end
            S_READ:
            begin
                if (dp_stat.done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (cfg_valid && cfg_ready)
        begin
            stale_next = 1'b1;
        end
    end

    // Datapath operation for each state.
    always_comb
    begin
        unique case (state_reg)
            S_CLEAR:  dp_cmd.op = OP_CLEAR;
            S_LD_PL:  dp_cmd.op = OP_LOAD_PL;
            S_LD_PR:  dp_cmd.op = OP_LOAD_PR;
            S_LD_OC:  dp_cmd.op = OP_LOAD_OC;
            S_MUL_PL,
            S_MUL_PR,
            S_MUL_OC: dp_cmd.op = OP_MUL;
            S_WR_C:   dp_cmd.op = OP_WR_COMB;
            S_WR_P:   dp_cmd.op = OP_WR_PAL;
            S_READ:   dp_cmd.op = OP_READ;
            default:  dp_cmd.op = OP_NONE;
        endcase
        dp_cmd.start   = go_reg && (dp_cmd.op != OP_NONE);
        dp_cmd.capture = accept;
        dp_cmd.hwr     = hwr_cmd;
        dp_cmd.sat_clr = sat_clr_cmd;
        dp_cmd.rd_zero = !in_use;
    end

    // State and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            go_reg        <= 1'b1;
            i_reg         <= '0;
            stale_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            bones_reg     <= 9'd1;
        end
        else
        begin
            state_reg <= state_next;
            go_reg    <= state_next != state_reg;
            i_reg     <= i_next;
            stale_reg <= stale_next;
            if (cfg_valid && cfg_ready)
            begin
                bones_reg <= bones_in_use;
            end
            if ((state_reg == S_READ) && dp_stat.done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign in_stall  = (state_reg != S_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign cfg_ready = 1'b1;
    assign bone_idx  = i_reg;

endmodule

/* hw/rtl/bone_palette_compose.sv */
// Skinning matrix palette. Matrices are loaded one row per request on the
// input channel (cmd, bone, row, col0..col3); a set-parent request links a
// bone to its parent or marks it a root. A read-row request returns one row
// of offset * combined for the bone on the output channel, with the flag
// saturated from the most recent recompute. The bones_in_use register is
// written through the cfg_valid / cfg_ready port, which is always ready.
// A write is applied in the dispatch state after acceptance. A clean read
// reads the row next, and the next request is taken in the cycle after the
// row leaves. A read after any write to a bone in use or a register change
// first walks all N bones in use: pose * local, times the parent's combined
// matrix for a bone with a parent, then offset * combined for the final
// matrices, on the single 32x32 multiplier that forms one product per
// cycle. After reset a clearing pass loads identity matrices and root
// links; in_stall stays high during it. While the output holds a result
// that the receiver stalls, in_stall stays high as well.
module bone_palette_compose #(
    parameter int MAX_BONES = bpc_pkg::MAX_BONES_DEF,
    parameter int FRAC_BITS = bpc_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         cmd,
    input  logic [7:0]         bone,
    input  logic [1:0]         row,
    input  logic signed [31:0] col0,
    input  logic signed [31:0] col1,
    input  logic signed [31:0] col2,
    input  logic signed [31:0] col3,
    input  logic [7:0]         parent_bone,
    input  logic               is_root,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] out_col0,
    output logic signed [31:0] out_col1,
    output logic signed [31:0] out_col2,
    output logic signed [31:0] out_col3,
    output logic               saturated,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [8:0]         bones_in_use
);
    import bpc_pkg::*;

    localparam int BIDX_W = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;

    dp_cmd_t           dp_cmd;
    dp_stat_t          dp_stat;
    logic [BIDX_W-1:0] bone_idx;
    row_t              in_row;
    row_t              out_row;

    assign in_row = {col3, col2, col1, col0};

    bpc_ctrl #(
        .MAX_BONES (MAX_BONES),
        .BIDX_W    (BIDX_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .bones_in_use (bones_in_use),
        .dp_stat      (dp_stat),
        .dp_cmd       (dp_cmd),
        .bone_idx     (bone_idx)
    );

    bpc_datapath #(
        .MAX_BONES (MAX_BONES),
        .FRAC_BITS (FRAC_BITS),
        .BIDX_W    (BIDX_W)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .dp_cmd      (dp_cmd),
        .bone_idx    (bone_idx),
        .cmd         (cmd),
        .bone        (bone),
        .row         (row),
        .in_row      (in_row),
        .parent_bone (parent_bone),
        .is_root     (is_root),
        .dp_stat     (dp_stat),
        .out_row     (out_row),
        .out_sat     (saturated)
    );

    assign out_col0 = $signed(out_row[0]);
    assign out_col1 = $signed(out_row[1]);
    assign out_col2 = $signed(out_row[2]);
    assign out_col3 = $signed(out_row[3]);

endmodule
